// ===== src/lhs_pkg.sv =====
package lhs_pkg;

    localparam int TICK_COUNT_WIDTH = 16;
    localparam int TIMEOUT_WIDTH    = 16;
    localparam int CMP_WIDTH        = (TICK_COUNT_WIDTH > TIMEOUT_WIDTH) ?
                                      TICK_COUNT_WIDTH : TIMEOUT_WIDTH;
    localparam int CFG_INDEX_WIDTH  = 3;

    localparam logic [TIMEOUT_WIDTH-1:0] CLIENT_RECV_TIMEOUT_RST     = 16'd10;
    localparam logic [TIMEOUT_WIDTH-1:0] CLIENT_SHUTDOWN_TIMEOUT_RST = 16'd20;
    localparam logic [TIMEOUT_WIDTH-1:0] CLIENT_SEND_TIMEOUT_RST     = 16'd12;
    localparam logic [TIMEOUT_WIDTH-1:0] SERVER_SEND_TIMEOUT_RST     = 16'd12;
    localparam logic [TIMEOUT_WIDTH-1:0] SERVER_SHUTDOWN_TIMEOUT_RST = 16'd15;

    typedef enum logic [2:0] {
        MODE_TICK       = 3'd0,
        MODE_CTRL_RECV  = 3'd1,
        MODE_DATA_RECV  = 3'd2,
        MODE_TX_DONE    = 3'd3,
        MODE_DISCONNECT = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        KIND_REQUEST  = 2'd0,
        KIND_RESPONSE = 2'd1,
        KIND_KEEPON   = 2'd2
    } ctrl_kind_t;

    typedef enum logic [1:0] {
        CTL_NONE     = 2'd0,
        CTL_REQUEST  = 2'd1,
        CTL_RESPONSE = 2'd2,
        CTL_KEEPON   = 2'd3
    } ctl_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_IS_SERVER               = 3'd0,
        REG_CLIENT_RECV_TIMEOUT     = 3'd1,
        REG_CLIENT_SHUTDOWN_TIMEOUT = 3'd2,
        REG_CLIENT_SEND_TIMEOUT     = 3'd3,
        REG_SERVER_SEND_TIMEOUT     = 3'd4,
        REG_SERVER_SHUTDOWN_TIMEOUT = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic                     is_server;
        logic [TIMEOUT_WIDTH-1:0] client_recv_timeout;
        logic [TIMEOUT_WIDTH-1:0] client_shutdown_timeout;
        logic [TIMEOUT_WIDTH-1:0] client_send_timeout;
        logic [TIMEOUT_WIDTH-1:0] server_send_timeout;
        logic [TIMEOUT_WIDTH-1:0] server_shutdown_timeout;
    } cfg_t;

endpackage

// ===== src/link_heartbeat_supervisor.sv =====
// Channel   Handshake              Payload
// input     in_valid / in_ready    mode[2:0], control_kind[1:0], link_up
// output    out_valid / out_ready  send_control[1:0], drop_link
// config    cfg_we                 cfg_index[2:0], cfg_data[15:0]
//
// An event is registered on transfer into the input register, and its result is registered into the output register.
// One event is taken per cycle while the output is not stalled; the counters and probe flag update in a single step.
// A stalled result holds in the output register while the next event waits in the input register.
// Reset restores the timeouts to their defaults and clears the counters and probe flag.
module link_heartbeat_supervisor
    import lhs_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [TIMEOUT_WIDTH-1:0]   cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [2:0]                 mode,
    input  logic [1:0]                 control_kind,
    input  logic                       link_up,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 send_control,
    output logic                       drop_link
);

    cfg_t cfg;

    lhs_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lhs_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .control_kind (control_kind),
        .link_up      (link_up),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .send_control (send_control),
        .drop_link    (drop_link)
    );

endmodule

// ===== src/lhs_cfg_regs.sv =====
module lhs_cfg_regs
    import lhs_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [TIMEOUT_WIDTH-1:0]   cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IS_SERVER:               cfg_next.is_server = cfg_data[0];
                REG_CLIENT_RECV_TIMEOUT:     cfg_next.client_recv_timeout = cfg_data;
                REG_CLIENT_SHUTDOWN_TIMEOUT: cfg_next.client_shutdown_timeout = cfg_data;
                REG_CLIENT_SEND_TIMEOUT:     cfg_next.client_send_timeout = cfg_data;
                REG_SERVER_SEND_TIMEOUT:     cfg_next.server_send_timeout = cfg_data;
                REG_SERVER_SHUTDOWN_TIMEOUT: cfg_next.server_shutdown_timeout = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.is_server               <= 1'b0;
            cfg_reg.client_recv_timeout     <= CLIENT_RECV_TIMEOUT_RST;
            cfg_reg.client_shutdown_timeout <= CLIENT_SHUTDOWN_TIMEOUT_RST;
            cfg_reg.client_send_timeout     <= CLIENT_SEND_TIMEOUT_RST;
            cfg_reg.server_send_timeout     <= SERVER_SEND_TIMEOUT_RST;
            cfg_reg.server_shutdown_timeout <= SERVER_SHUTDOWN_TIMEOUT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/lhs_engine.sv =====
module lhs_engine
    import lhs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] mode,
    input  logic [1:0] control_kind,
    input  logic       link_up,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] send_control,
    output logic       drop_link
);

    localparam logic [TICK_COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [2:0] mode_reg;
    logic [1:0] kind_reg;
    logic       link_reg;

    logic [TICK_COUNT_WIDTH-1:0] recv_ticks_reg;
    logic [TICK_COUNT_WIDTH-1:0] recv_ticks_next;
    logic [TICK_COUNT_WIDTH-1:0] send_ticks_reg;
    logic [TICK_COUNT_WIDTH-1:0] send_ticks_next;
    logic                        probe_reg;
    logic                        probe_next;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [1:0]                  send_reg;
    logic                        drop_reg;

    logic                        advance;
    logic [TICK_COUNT_WIDTH-1:0] recv_inc;
    logic [TICK_COUNT_WIDTH-1:0] send_inc;
    logic [CMP_WIDTH-1:0]        recv_cmp;
    logic [CMP_WIDTH-1:0]        send_cmp;
    logic [1:0]                  send_calc;
    logic                        drop_calc;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign recv_inc = (recv_ticks_reg == COUNT_MAX) ? COUNT_MAX : recv_ticks_reg + 1'b1;
    assign send_inc = (send_ticks_reg == COUNT_MAX) ? COUNT_MAX : send_ticks_reg + 1'b1;
    assign recv_cmp = CMP_WIDTH'(recv_inc);
    assign send_cmp = CMP_WIDTH'(send_inc);

    always_comb
    begin
        recv_ticks_next = recv_ticks_reg;
        send_ticks_next = send_ticks_reg;
        probe_next      = probe_reg;
        send_calc       = CTL_NONE;
        drop_calc       = 1'b0;
        unique case (mode_reg)
            MODE_TICK:
            begin
                if (link_reg)
                begin
                    recv_ticks_next = recv_inc;
                    send_ticks_next = send_inc;
                    if (cfg.is_server)
                    begin
                        if (recv_cmp > CMP_WIDTH'(cfg.server_shutdown_timeout))
                        begin
                            drop_calc = 1'b1;
                        end
                        if (send_cmp > CMP_WIDTH'(cfg.server_send_timeout))
                        begin
                            send_calc = CTL_KEEPON;
                        end
                    end
                    else if (recv_cmp > CMP_WIDTH'(cfg.client_recv_timeout) && !probe_reg)
                    begin
                        send_calc  = CTL_REQUEST;
                        probe_next = 1'b1;
                    end
                    else if (recv_cmp > CMP_WIDTH'(cfg.client_shutdown_timeout))
                    begin
                        drop_calc = 1'b1;
                    end
                    else if (send_cmp > CMP_WIDTH'(cfg.client_send_timeout) && !probe_reg)
                    begin
                        send_calc = CTL_KEEPON;
                    end
                end
            end
            MODE_CTRL_RECV:
            begin
                recv_ticks_next = '0;
                if (kind_reg == KIND_REQUEST)
                begin
                    send_calc = CTL_RESPONSE;
                end
                else if (kind_reg == KIND_RESPONSE)
                begin
                    probe_next = 1'b0;
                end
            end
            MODE_DATA_RECV:
            begin
                recv_ticks_next = '0;
            end
            MODE_TX_DONE:
            begin
                send_ticks_next = '0;
            end
            MODE_DISCONNECT:
            begin
                recv_ticks_next = '0;
                send_ticks_next = '0;
                probe_next      = 1'b0;
            end
            default:
            begin
                probe_next = probe_reg;
            end
        endcase
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            recv_ticks_reg <= '0;
            send_ticks_reg <= '0;
            probe_reg      <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                recv_ticks_reg <= recv_ticks_next;
                send_ticks_reg <= send_ticks_next;
                probe_reg      <= probe_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg <= mode;
            kind_reg <= control_kind;
            link_reg <= link_up;
        end
        if (advance)
        begin
            send_reg <= send_calc;
            drop_reg <= drop_calc;
        end
    end

    assign out_valid    = out_valid_reg;
    assign send_control = send_reg;
    assign drop_link    = drop_reg;

endmodule

// ===== tb/link_heartbeat_supervisor_tb.sv =====
module link_heartbeat_supervisor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lhs_pkg::*;

    localparam logic [2:0] MODE_UNUSED_5 = 3'd5;
    localparam logic [2:0] MODE_UNUSED_7 = 3'd7;
    localparam logic [1:0] KIND_UNKNOWN  = 2'd3;
    localparam int LATENCY_PAD  = 4;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASES       = 12;
    localparam int PHASE_EVENTS = 125;
    localparam int REPORT_CAP   = 100;

    typedef struct packed {
        logic [1:0] send;
        logic       drop;
    } verdict_t;

    typedef struct {
        bit                       is_write;
        reg_index_t               idx;
        logic [TIMEOUT_WIDTH-1:0] value;
        logic [2:0]               m;
        logic [1:0]               k;
        logic                     l;
        bit                       typed;
        logic [1:0]               t_send;
        logic                     t_drop;
    } plan_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [TIMEOUT_WIDTH-1:0]   cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [2:0]                 mode = '0;
    logic [1:0]                 control_kind = '0;
    logic                       link_up = 1'b0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [1:0]                 send_control;
    logic                       drop_link;

    cfg_t                        shadow_cfg;
    logic [TICK_COUNT_WIDTH-1:0] rx_idle;
    logic [TICK_COUNT_WIDTH-1:0] tx_idle;
    logic                        probe_out;

    verdict_t  pending_verdicts[$];
    plan_row_t plan[$];
    verdict_t  want;
    int        failures = 0;
    int        cycles = 0;
    bit        steady = 1'b0;

    link_heartbeat_supervisor i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .control_kind (control_kind),
        .link_up      (link_up),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .send_control (send_control),
        .drop_link    (drop_link)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic verdict_t supervise(logic [2:0] m, logic [1:0] k, logic l);
        verdict_t v;
        v.send = CTL_NONE;
        v.drop = 1'b0;
        case (m)
            MODE_TICK:
            begin
                if (l)
                begin
                    if (rx_idle != '1)
                        rx_idle = rx_idle + 1'b1;
                    if (tx_idle != '1)
                        tx_idle = tx_idle + 1'b1;
                    if (shadow_cfg.is_server)
                    begin
                        if (rx_idle > shadow_cfg.server_shutdown_timeout)
                            v.drop = 1'b1;
                        if (tx_idle > shadow_cfg.server_send_timeout)
                            v.send = CTL_KEEPON;
                    end
                    else if (rx_idle > shadow_cfg.client_recv_timeout && !probe_out)
                    begin
                        v.send = CTL_REQUEST;
                        probe_out = 1'b1;
                    end
                    else if (rx_idle > shadow_cfg.client_shutdown_timeout)
                        v.drop = 1'b1;
                    else if (tx_idle > shadow_cfg.client_send_timeout && !probe_out)
                        v.send = CTL_KEEPON;
                end
            end
            MODE_CTRL_RECV:
            begin
                rx_idle = '0;
                if (k == KIND_REQUEST)
                    v.send = CTL_RESPONSE;
                else if (k == KIND_RESPONSE)
                    probe_out = 1'b0;
            end
            MODE_DATA_RECV:
                rx_idle = '0;
            MODE_TX_DONE:
                tx_idle = '0;
            MODE_DISCONNECT:
            begin
                rx_idle = '0;
                tx_idle = '0;
                probe_out = 1'b0;
            end
            default: ;
        endcase
        return v;
    endfunction

    function automatic plan_row_t ev(logic [2:0] m, logic [1:0] k, logic l);
        plan_row_t r;
        r = '{idx: REG_IS_SERVER, default: '0};
        r.m = m;
        r.k = k;
        r.l = l;
        return r;
    endfunction

    function automatic plan_row_t evt(logic [2:0] m, logic [1:0] k, logic l,
                                      logic [1:0] s, logic d);
        plan_row_t r;
        r = ev(m, k, l);
        r.typed = 1'b1;
        r.t_send = s;
        r.t_drop = d;
        return r;
    endfunction

    function automatic plan_row_t wr(reg_index_t idx, logic [TIMEOUT_WIDTH-1:0] value);
        plan_row_t r;
        r = '{idx: REG_IS_SERVER, default: '0};
        r.is_write = 1'b1;
        r.idx = idx;
        r.value = value;
        return r;
    endfunction

    task automatic report(string field, int exp_v, int got_v);
        failures++;
        if (failures <= REPORT_CAP)
            $error("%s: expected %0d, actual %0d", field, exp_v, got_v);
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("link_heartbeat_supervisor: mismatch");
            $finish;
        end
    end

    always @(negedge clk)
        out_ready = steady || ($urandom_range(99) >= 14);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_verdicts.size() == 0)
                report("unexpected result, send_control", -1, send_control);
            else
            begin
                want = pending_verdicts.pop_front();
                if (send_control !== want.send)
                    report("send_control", want.send, send_control);
                if (drop_link !== want.drop)
                    report("drop_link", want.drop, drop_link);
            end
        end
    end

    task automatic offer(logic [2:0] m, logic [1:0] k, logic l, bit typed,
                         logic [1:0] t_send, logic t_drop);
        verdict_t v;
        while (!steady && $urandom_range(99) < 14)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        mode = m;
        control_kind = k;
        link_up = l;
        do
            @(posedge clk);
        while (!in_ready);
        v = supervise(m, k, l);
        if (typed)
        begin
            v.send = t_send;
            v.drop = t_drop;
        end
        pending_verdicts.push_back(v);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid = 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (LATENCY_PAD) @(negedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [TIMEOUT_WIDTH-1:0] value);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(posedge clk);
        case (idx)
            REG_IS_SERVER:               shadow_cfg.is_server = value[0];
            REG_CLIENT_RECV_TIMEOUT:     shadow_cfg.client_recv_timeout = value;
            REG_CLIENT_SHUTDOWN_TIMEOUT: shadow_cfg.client_shutdown_timeout = value;
            REG_CLIENT_SEND_TIMEOUT:     shadow_cfg.client_send_timeout = value;
            REG_SERVER_SEND_TIMEOUT:     shadow_cfg.server_send_timeout = value;
            REG_SERVER_SHUTDOWN_TIMEOUT: shadow_cfg.server_shutdown_timeout = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [TIMEOUT_WIDTH-1:0] pick_timeout();
        int r;
        r = $urandom_range(19);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else if (r == 2)
            return TIMEOUT_WIDTH'($urandom);
        return TIMEOUT_WIDTH'($urandom_range(12, 1));
    endfunction

    task automatic random_event(int chatter);
        int         r;
        logic [2:0] m;
        logic [1:0] k;
        logic       l;
        r = $urandom_range(99);
        k = 2'($urandom_range(3));
        l = 1'($urandom_range(1));
        if (r < chatter)
            m = ($urandom_range(3) != 0) ? MODE_CTRL_RECV : MODE_DATA_RECV;
        else if (r < 2 * chatter)
            m = MODE_TX_DONE;
        else if (r < 2 * chatter + 2)
        begin
            m = MODE_TICK;
            l = 1'b0;
        end
        else if (r < 2 * chatter + 3)
            m = 3'($urandom_range(MODE_UNUSED_7, MODE_UNUSED_5));
        else if (r < 2 * chatter + 4)
            m = MODE_DISCONNECT;
        else
        begin
            m = MODE_TICK;
            l = 1'b1;
        end
        offer(m, k, l, 1'b0, CTL_NONE, 1'b0);
    endtask

    initial
    begin
        plan_row_t row;
        int        chatter;

        shadow_cfg.is_server = 1'b0;
        shadow_cfg.client_recv_timeout = CLIENT_RECV_TIMEOUT_RST;
        shadow_cfg.client_shutdown_timeout = CLIENT_SHUTDOWN_TIMEOUT_RST;
        shadow_cfg.client_send_timeout = CLIENT_SEND_TIMEOUT_RST;
        shadow_cfg.server_send_timeout = SERVER_SEND_TIMEOUT_RST;
        shadow_cfg.server_shutdown_timeout = SERVER_SHUTDOWN_TIMEOUT_RST;
        rx_idle = '0;
        tx_idle = '0;
        probe_out = 1'b0;

        plan.push_back(evt(MODE_TICK, KIND_REQUEST, 1'b0, CTL_NONE, 1'b0));
        plan.push_back(evt(MODE_CTRL_RECV, KIND_REQUEST, 1'b0, CTL_RESPONSE, 1'b0));
        plan.push_back(ev(MODE_CTRL_RECV, KIND_RESPONSE, 1'b1));
        plan.push_back(ev(MODE_CTRL_RECV, KIND_KEEPON, 1'b1));
        plan.push_back(evt(MODE_CTRL_RECV, KIND_UNKNOWN, 1'b0, CTL_NONE, 1'b0));
        plan.push_back(ev(MODE_DATA_RECV, KIND_KEEPON, 1'b1));
        plan.push_back(ev(MODE_TX_DONE, KIND_RESPONSE, 1'b0));
        plan.push_back(evt(MODE_UNUSED_5, KIND_UNKNOWN, 1'b1, CTL_NONE, 1'b0));
        plan.push_back(evt(MODE_UNUSED_7, KIND_REQUEST, 1'b1, CTL_NONE, 1'b0));
        plan.push_back(ev(MODE_TICK, KIND_UNKNOWN, 1'b1));
        plan.push_back(ev(MODE_DISCONNECT, KIND_REQUEST, 1'b0));
        plan.push_back(wr(REG_CLIENT_RECV_TIMEOUT, '0));
        plan.push_back(wr(REG_CLIENT_SHUTDOWN_TIMEOUT, '0));
        plan.push_back(wr(REG_CLIENT_SEND_TIMEOUT, '0));
        plan.push_back(wr(REG_SERVER_SEND_TIMEOUT, '0));
        plan.push_back(wr(REG_SERVER_SHUTDOWN_TIMEOUT, '0));
        plan.push_back(evt(MODE_TICK, KIND_REQUEST, 1'b1, CTL_REQUEST, 1'b0));
        plan.push_back(evt(MODE_TICK, KIND_REQUEST, 1'b1, CTL_NONE, 1'b1));
        plan.push_back(ev(MODE_CTRL_RECV, KIND_RESPONSE, 1'b1));
        plan.push_back(evt(MODE_TICK, KIND_KEEPON, 1'b1, CTL_REQUEST, 1'b0));
        plan.push_back(ev(MODE_CTRL_RECV, KIND_REQUEST, 1'b1));
        plan.push_back(ev(MODE_DISCONNECT, KIND_UNKNOWN, 1'b1));
        plan.push_back(wr(REG_CLIENT_RECV_TIMEOUT, '1));
        plan.push_back(wr(REG_CLIENT_SHUTDOWN_TIMEOUT, '1));
        plan.push_back(evt(MODE_TICK, KIND_REQUEST, 1'b1, CTL_KEEPON, 1'b0));
        plan.push_back(wr(REG_IS_SERVER, 16'h0001));
        plan.push_back(evt(MODE_TICK, KIND_REQUEST, 1'b1, CTL_KEEPON, 1'b1));
        plan.push_back(ev(MODE_TX_DONE, KIND_REQUEST, 1'b1));
        plan.push_back(ev(MODE_TICK, KIND_RESPONSE, 1'b1));
        plan.push_back(wr(REG_SERVER_SEND_TIMEOUT, '1));
        plan.push_back(wr(REG_SERVER_SHUTDOWN_TIMEOUT, '1));
        plan.push_back(evt(MODE_TICK, KIND_REQUEST, 1'b1, CTL_NONE, 1'b0));
        plan.push_back(ev(MODE_DISCONNECT, KIND_REQUEST, 1'b1));

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            row = plan[i];
            if (row.is_write)
            begin
                drain_results();
                write_reg(row.idx, row.value);
            end
            else
                offer(row.m, row.k, row.l, row.typed, row.t_send, row.t_drop);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_results();
            steady = (ph == 4 || ph == 5);
            write_reg(REG_IS_SERVER, TIMEOUT_WIDTH'(ph % 2));
            write_reg(REG_CLIENT_RECV_TIMEOUT, pick_timeout());
            write_reg(REG_CLIENT_SHUTDOWN_TIMEOUT, pick_timeout());
            write_reg(REG_CLIENT_SEND_TIMEOUT, pick_timeout());
            write_reg(REG_SERVER_SEND_TIMEOUT, pick_timeout());
            write_reg(REG_SERVER_SHUTDOWN_TIMEOUT, pick_timeout());
            chatter = $urandom_range(20, 2);
            for (int n = 0; n < PHASE_EVENTS; n++)
            begin
                random_event(chatter);
                if (n % 40 == 39)
                    drain_results();
            end
        end

        steady = 1'b0;
        drain_results();
        if (failures == 0)
            $display("link_heartbeat_supervisor: match");
        else
            $display("link_heartbeat_supervisor: mismatch");
        $finish;
    end

endmodule
